// ===== rtl/core/tcce_pkg.sv =====
`timescale 1ns / 1ps

package tcce_pkg;

   // Screen geometry
   localparam int COLS      = 80;
   localparam int ROWS      = 25;
   localparam int TAB_WIDTH = 4;
   localparam int CELLS     = ROWS * COLS;

   localparam int COL_W  = $clog2(COLS);
   localparam int ROW_W  = $clog2(ROWS + 1);
   localparam int TAB_W  = $clog2(TAB_WIDTH + 1);
   localparam int ADDR_W = $clog2(CELLS);

   localparam logic [7:0] COLOR_AT_RESET = 8'h07;

   // Command codes
   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Control characters
   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_RETURN  = 8'd13;
   localparam logic [7:0] CH_SPACE   = 8'd32;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] ch;
      logic [6:0] cell_x;
      logic [4:0] cell_y;
   } req_type;

   typedef struct packed {
      logic [6:0]  cursor_col;
      logic [4:0]  cursor_row;
      logic [10:0] cursor_pos;
      logic [7:0]  read_char;
      logic [7:0]  read_color;
      logic        scrolled;
   } rsp_type;

endpackage

// ===== rtl/core/text_console_cursor_engine_core.sv =====
`timescale 1ns / 1ps
// Sequence: a printable put passes ST_PUT, ST_CHECK and ST_FINISH; a read passes
// ST_READ, ST_RDATA and ST_FINISH; a tab writes spaces in ST_TAB up to a tab stop; a newline
// checks the row; a return or cmd 3 goes straight to ST_FINISH; a scroll or a clear sweeps all CELLS cells.
// Throughput: one transaction at a time, sweeps set by the store's one write port.
// Reset (synchronous, active high) homes the cursor and starts a clearing pass
// over the store; req_ready stays low until it completes.
module text_console_cursor_engine_core
   import tcce_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata
);

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_PUT,
      ST_TAB,
      ST_CHECK,
      ST_READ,
      ST_RDATA,
      ST_FINISH
   } state_type;

   state_type           state_ff, state_in;
   req_type             req_ff, req_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [TAB_W-1:0]    phase_ff, phase_in;
   logic [ADDR_W-1:0]   sweep_ff, sweep_in;
   logic                scroll_mode_ff, scroll_mode_in;
   logic                boot_ff, boot_in;
   logic                pend_ff, pend_in;
   logic                pend_copy_ff, pend_copy_in;
   logic [ADDR_W-1:0]   pend_addr_ff, pend_addr_in;
   logic [7:0]          screen_color_ff, screen_color_in;
   logic [7:0]          default_color_ff, default_color_in;
   logic [7:0]          rd_char_ff, rd_char_in;
   logic [7:0]          rd_color_ff, rd_color_in;
   logic                scrolled_ff, scrolled_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   // Character store; every cell shares one color, so only characters live here
   logic [7:0]          char_mem [CELLS];
   logic [7:0]          mem_rdata_ff;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [7:0]          mem_wdata;
   logic [ADDR_W-1:0]   mem_raddr;

   // Shared address unit: row * COLS + column
   logic [ROW_W-1:0]    addr_row;
   logic [COL_W-1:0]    addr_col;
   logic [ADDR_W-1:0]   addr_lin;

   // Cursor advance by one cell
   logic                adv_wrap;
   logic [COL_W-1:0]    adv_col;
   logic [TAB_W-1:0]    adv_phase;

   logic                read_in_range;
   logic                sweep_copy;
   logic                sweep_last;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Cell address comes from the read request only while a read is issued
   always_comb begin
      if (state_ff == ST_READ) begin
         addr_row = ROW_W'(req_ff.cell_y);
         addr_col = COL_W'(req_ff.cell_x);
      end else begin
         addr_row = row_ff;
         addr_col = col_ff;
      end
      addr_lin = ADDR_W'(ADDR_W'(addr_row) * ADDR_W'(COLS) + ADDR_W'(addr_col));
   end

   assign read_in_range = ({1'b0, req_ff.cell_x} < 8'(COLS)) &&
                          ({2'b0, req_ff.cell_y} < 7'(ROWS));

   // Advance one cell; wrapping to the next row lands on a tab stop
   assign adv_wrap  = (col_ff == COL_W'(COLS - 1));
   assign adv_col   = adv_wrap ? '0 : COL_W'(col_ff + 1'b1);
   assign adv_phase = (adv_wrap || phase_ff == TAB_W'(TAB_WIDTH - 1)) ? '0
                                                                    : TAB_W'(phase_ff + 1'b1);

   // Scroll copies row r+1 into row r; the bottom row and a clear write zeros
   assign sweep_copy = scroll_mode_ff && (sweep_ff < ADDR_W'(CELLS - COLS));
   assign sweep_last = (sweep_ff == ADDR_W'(CELLS - 1));

   // Memory ports: the delayed sweep write has the port to itself
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_lin;
      mem_wdata = req_ff.ch;
      if (pend_ff) begin
         mem_we    = 1'b1;
         mem_waddr = pend_addr_ff;
         mem_wdata = pend_copy_ff ? mem_rdata_ff : '0;
      end else if (state_ff == ST_PUT) begin
         mem_we = 1'b1;
      end else if (state_ff == ST_TAB) begin
         mem_we    = 1'b1;
         mem_wdata = CH_SPACE;
      end

      if (state_ff == ST_SWEEP) begin
         mem_raddr = sweep_copy ? ADDR_W'(sweep_ff + COLS) : sweep_ff;
      end else if (state_ff == ST_READ && read_in_range) begin
         mem_raddr = addr_lin;
      end else begin
         mem_raddr = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         char_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= char_mem[mem_raddr];
   end

   // Sequencer
   always_comb begin
      state_in         = state_ff;
      req_in           = req_ff;
      col_in           = col_ff;
      row_in           = row_ff;
      phase_in         = phase_ff;
      sweep_in         = sweep_ff;
      scroll_mode_in   = scroll_mode_ff;
      boot_in          = boot_ff;
      pend_in          = 1'b0;
      pend_copy_in     = pend_copy_ff;
      pend_addr_in     = pend_addr_ff;
      screen_color_in  = screen_color_ff;
      default_color_in = csr_we ? csr_wdata : default_color_ff;
      rd_char_in       = rd_char_ff;
      rd_color_in      = rd_color_ff;
      scrolled_in      = scrolled_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_in           = rsp_ff;

      unique case (state_ff)
         ST_SWEEP: begin
            // Issue one cell; its write lands in the next cycle
            pend_in      = 1'b1;
            pend_copy_in = sweep_copy;
            pend_addr_in = sweep_ff;
            sweep_in     = ADDR_W'(sweep_ff + 1'b1);
            if (sweep_last) begin
               state_in = boot_ff ? ST_IDLE : ST_FINISH;
               boot_in  = 1'b0;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in      = req_data;
               scrolled_in = 1'b0;
               rd_char_in  = '0;
               rd_color_in = '0;
               unique case (req_data.cmd)
                  CMD_PUT: begin
                     unique case (req_data.ch)
                        CH_NEWLINE: begin
                           col_in   = '0;
                           phase_in = '0;
                           row_in   = ROW_W'(row_ff + 1'b1);
                           state_in = ST_CHECK;
                        end
                        CH_RETURN: begin
                           col_in   = '0;
                           phase_in = '0;
                           state_in = ST_FINISH;
                        end
                        CH_TAB: begin
                           state_in = ST_TAB;
                        end
                        default: begin
                           state_in = ST_PUT;
                        end
                     endcase
                  end
                  CMD_CLEAR: begin
                     screen_color_in = default_color_ff;
                     col_in          = '0;
                     row_in          = '0;
                     phase_in        = '0;
                     sweep_in        = '0;
                     scroll_mode_in  = 1'b0;
                     state_in        = ST_SWEEP;
                  end
                  CMD_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_PUT: begin
            col_in   = adv_col;
            phase_in = adv_phase;
            if (adv_wrap) begin
               row_in = ROW_W'(row_ff + 1'b1);
            end
            state_in = ST_CHECK;
         end
         ST_TAB: begin
            // Write one space per cycle until a tab stop or the line end
            col_in   = adv_col;
            phase_in = adv_phase;
            if (adv_wrap) begin
               row_in = ROW_W'(row_ff + 1'b1);
            end
            if (adv_wrap || adv_phase == '0) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (row_ff >= ROW_W'(ROWS)) begin
               scrolled_in     = 1'b1;
               screen_color_in = default_color_ff;
               row_in          = ROW_W'(ROWS - 1);
               sweep_in        = '0;
               scroll_mode_in  = 1'b1;
               state_in        = ST_SWEEP;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_READ: begin
            state_in = ST_RDATA;
         end
         ST_RDATA: begin
            rd_char_in  = read_in_range ? mem_rdata_ff : '0;
            rd_color_in = read_in_range ? screen_color_ff : '0;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.cursor_col = 7'(col_ff);
               rsp_in.cursor_row = 5'(row_ff);
               rsp_in.cursor_pos = 11'(addr_lin);
               rsp_in.read_char  = rd_char_ff;
               rsp_in.read_color = rd_color_ff;
               rsp_in.scrolled   = scrolled_ff;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_SWEEP;
         col_ff           <= '0;
         row_ff           <= '0;
         phase_ff         <= '0;
         sweep_ff         <= '0;
         scroll_mode_ff   <= 1'b0;
         boot_ff          <= 1'b1;
         pend_ff          <= 1'b0;
         screen_color_ff  <= COLOR_AT_RESET;
         default_color_ff <= COLOR_AT_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         col_ff           <= col_in;
         row_ff           <= row_in;
         phase_ff         <= phase_in;
         sweep_ff         <= sweep_in;
         scroll_mode_ff   <= scroll_mode_in;
         boot_ff          <= boot_in;
         pend_ff          <= pend_in;
         screen_color_ff  <= screen_color_in;
         default_color_ff <= default_color_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      req_ff       <= req_in;
      pend_copy_ff <= pend_copy_in;
      pend_addr_ff <= pend_addr_in;
      rd_char_ff   <= rd_char_in;
      rd_color_ff  <= rd_color_in;
      scrolled_ff  <= scrolled_in;
      rsp_ff       <= rsp_in;
   end

endmodule

// ===== rtl/core/tcce_core_checker.sv =====
`timescale 1ns / 1ps
module tcce_core_checker
   import tcce_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input rsp_type    rsp_data
);

   // Stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // One transaction in flight: ready drops right after acceptance
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while busy");

   // A new result appears only at the end of work, never straight from idle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result without work");

   // Clearing pass follows reset
   assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("ready during clearing pass");

endmodule

bind text_console_cursor_engine_core tcce_core_checker u_checker (.*);
